### design/tgr_pkg.sv
// tgr_pkg: shared types, constants and the 5x7 font for the text glyph renderer.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tgr_pkg;

  // Coordinate and frame sizes
  localparam int COORD_W       = 16;
  localparam int MAX_FRAME_DIM = 4096;
  localparam int DIM_W         = $clog2(MAX_FRAME_DIM);
  localparam int LIM_W         = DIM_W + 1;
  localparam int DIM_REG_W     = 13;
  localparam int PITCH_W       = 14;
  localparam int ADDR_W        = 48;
  localparam int COLOR_W       = 32;
  localparam int CHAR_W        = 8;
  localparam int ORIGIN_W      = 16;

  // Glyph geometry
  localparam int GLYPH_ROWS   = 7;
  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_W      = GLYPH_ROWS * GLYPH_COLS;
  localparam int ROW_W        = $clog2(GLYPH_ROWS);
  localparam int CELL_ADVANCE = 6;
  localparam int LINE_ADVANCE = 9;

  // Address arithmetic widths
  localparam int PROD_W = DIM_W + PITCH_W;
  localparam int OFF_W  = ((PROD_W > COORD_W) ? PROD_W : COORD_W) + 1;
  localparam int CMP_W  = ((COORD_W > LIM_W) ? COORD_W : LIM_W) + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_READY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE   = 3'd4;

  // Character codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] LOWER_A      = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z      = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  // Job queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic                first;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [CHAR_W-1:0]   character;
    logic [COLOR_W-1:0]  ink_color;
  } tgr_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]     row_address;
    logic [GLYPH_COLS-1:0] pixel_mask;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  last;
  } tgr_out_t;

  // Frame settings as seen by the datapath (limits already capped)
  typedef struct packed {
    logic               ready;
    logic [LIM_W-1:0]   wlim;
    logic [LIM_W-1:0]   hlim;
    logic [PITCH_W-1:0] pitch;
    logic [ADDR_W-1:0]  base;
  } tgr_cfg_t;

  // One character to draw, handed from front to back
  typedef struct packed {
    logic [PROD_W-1:0]     prod;   // cursor_y * pitch
    logic [COORD_W-1:0]    cx;
    logic [DIM_W-1:0]      cy;
    logic [GLYPH_COLS-1:0] colen;  // columns left of the clip limit
    logic [GLYPH_W-1:0]    glyph;  // top row in the high bits
    logic [COLOR_W-1:0]    ink;
  } tgr_job_t;

  // Clamp a frame dimension to the largest supported size
  function automatic logic [LIM_W-1:0] cap_dim(input logic [DIM_REG_W-1:0] d);
    logic [LIM_W-1:0] r;
    if (32'(d) > MAX_FRAME_DIM) r = LIM_W'(MAX_FRAME_DIM);
    else r = LIM_W'(d);
    return r;
  endfunction

  // Font lookup with lower case folded onto upper case; unknown codes are blank
  function automatic logic [GLYPH_W-1:0] font_glyph(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0]  c;
    logic [GLYPH_W-1:0] g;
    c = code;
    if (c >= LOWER_A && c <= LOWER_Z) c = c - CASE_OFFSET;
    case (c)
      8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // A
      8'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E}; // B
      8'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E}; // C
      8'h44: g = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C}; // D
      8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}; // E
      8'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10}; // F
      8'h47: g = {5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F}; // G
      8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // H
      8'h49: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F}; // I
      8'h4A: g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C}; // J
      8'h4B: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11}; // K
      8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}; // L
      8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11}; // M
      8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11}; // N
      8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // O
      8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10}; // P
      8'h51: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D}; // Q
      8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11}; // R
      8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E}; // S
      8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // T
      8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // U
      8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04}; // V
      8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A}; // W
      8'h58: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11}; // X
      8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04}; // Y
      8'h5A: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}; // Z
      8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}; // 0
      8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // 1
      8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F}; // 2
      8'h33: g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E}; // 3
      8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}; // 4
      8'h35: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E}; // 5
      8'h36: g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}; // 6
      8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}; // 7
      8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}; // 8
      8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}; // 9
      8'h3A: g = {5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00}; // colon
      8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C}; // period
      8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}; // minus
      8'h2B: g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00}; // plus
      8'h2F: g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00}; // slash
      8'h2A: g = {5'h00, 5'h15, 5'h0E, 5'h1F, 5'h0E, 5'h15, 5'h00}; // star
      8'h3D: g = {5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}; // equals
      8'h5F: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F}; // underscore
      default: g = '0;                                              // space, unknown
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

### design/tgr_front.sv
// tgr_front: input side of the glyph renderer. Keeps the text cursor, looks up
// the glyph and queues one job per drawable character. Depends on tgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgr_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tgr_pkg::tgr_cfg_t cfg,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire tgr_pkg::tgr_in_t in_data,
  input  wire logic             q_ready,
  output logic                  q_push,
  output tgr_pkg::tgr_job_t     q_data
);

  logic [tgr_pkg::COORD_W-1:0] cursor_x_r, cursor_x_nxt;
  logic [tgr_pkg::COORD_W-1:0] cursor_y_r, cursor_y_nxt;
  logic [tgr_pkg::COORD_W-1:0] line_x_r, line_x_nxt;

  logic                        accept;
  logic                        is_newline;
  logic                        row0_inside;
  logic [tgr_pkg::COORD_W-1:0] cx_eff, cy_eff, line_eff;
  logic [tgr_pkg::COORD_W:0]   cx_sum, cy_sum;
  logic [tgr_pkg::COORD_W-1:0] cx_adv, cy_adv;
  logic [tgr_pkg::DIM_W-1:0]   cy_short;
  logic [tgr_pkg::GLYPH_COLS-1:0] colen;

  assign in_stall = !q_ready;
  assign accept   = in_valid && !in_stall;

  // Origin latch for the first character of a string
  always_comb begin
    if (in_data.first) begin
      cx_eff   = tgr_pkg::COORD_W'(in_data.origin_x);
      cy_eff   = tgr_pkg::COORD_W'(in_data.origin_y);
      line_eff = tgr_pkg::COORD_W'(in_data.origin_x);
    end else begin
      cx_eff   = cursor_x_r;
      cy_eff   = cursor_y_r;
      line_eff = line_x_r;
    end
  end

  assign is_newline = (in_data.character == tgr_pkg::NEWLINE_CODE);

  // Saturating cursor steps
  assign cx_sum = {1'b0, cx_eff} + (tgr_pkg::COORD_W+1)'(tgr_pkg::CELL_ADVANCE);
  assign cy_sum = {1'b0, cy_eff} + (tgr_pkg::COORD_W+1)'(tgr_pkg::LINE_ADVANCE);
  assign cx_adv = cx_sum[tgr_pkg::COORD_W] ? '1 : cx_sum[tgr_pkg::COORD_W-1:0];
  assign cy_adv = cy_sum[tgr_pkg::COORD_W] ? '1 : cy_sum[tgr_pkg::COORD_W-1:0];

  // Cursor update, done whether or not anything is drawn
  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    line_x_nxt   = line_x_r;
    if (accept) begin
      line_x_nxt = line_eff;
      if (is_newline) begin
        cursor_x_nxt = line_eff;
        cursor_y_nxt = cy_adv;
      end else begin
        cursor_x_nxt = cx_adv;
        cursor_y_nxt = cy_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      line_x_r   <= '0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      line_x_r   <= line_x_nxt;
    end
  end

  // Rows are contiguous from the top, so the character draws iff its top row fits
  assign row0_inside = (tgr_pkg::CMP_W'(cy_eff) < tgr_pkg::CMP_W'(cfg.hlim));
  assign q_push      = accept && !is_newline && cfg.ready && row0_inside;
  assign cy_short    = cy_eff[tgr_pkg::DIM_W-1:0];

  // Column clip flags: bit (4-col) for column col
  always_comb begin
    for (int col = 0; col < tgr_pkg::GLYPH_COLS; col++) begin
      colen[tgr_pkg::GLYPH_COLS-1-col] =
        (tgr_pkg::CMP_W'(cx_eff) + tgr_pkg::CMP_W'(col)) < tgr_pkg::CMP_W'(cfg.wlim);
    end
  end

  // Job payload
  always_comb begin
    q_data.prod  = tgr_pkg::PROD_W'(cy_short) * tgr_pkg::PROD_W'(cfg.pitch);
    q_data.cx    = cx_eff;
    q_data.cy    = cy_short;
    q_data.colen = colen;
    q_data.glyph = tgr_pkg::font_glyph(in_data.character);
    q_data.ink   = in_data.ink_color;
  end

endmodule

`default_nettype wire

### design/tgr_queue.sv
// tgr_queue: short job queue between the front and back of the glyph renderer.
// Flip-flop storage, one read at the head. Depends on tgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgr_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire tgr_pkg::tgr_job_t push_data,
  output logic                   ready,
  input  wire logic              pop,
  output logic                   valid,
  output tgr_pkg::tgr_job_t      head
);

  tgr_pkg::tgr_job_t            mem_r [tgr_pkg::Q_DEPTH];
  logic [tgr_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [tgr_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [tgr_pkg::Q_CNT_W-1:0]  count_r, count_nxt;

  assign ready = (count_r != tgr_pkg::Q_CNT_W'(tgr_pkg::Q_DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tgr_pkg::Q_PTR_W'(tgr_pkg::Q_DEPTH - 1)) ? '0
                                                                       : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tgr_pkg::Q_PTR_W'(tgr_pkg::Q_DEPTH - 1)) ? '0
                                                                       : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

### design/tgr_back.sv
// tgr_back: output side of the glyph renderer. Walks the glyph rows of one job,
// one row write per cycle when not stalled, to a registered output. Depends on tgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tgr_pkg::tgr_cfg_t cfg,
  input  wire logic              q_valid,
  input  wire tgr_pkg::tgr_job_t q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tgr_pkg::tgr_out_t      out_data
);

  logic                            active_r, active_nxt;
  logic [tgr_pkg::OFF_W-1:0]       off_r;
  logic [tgr_pkg::DIM_W-1:0]       y_r;
  logic [tgr_pkg::ROW_W-1:0]       row_r;
  logic [tgr_pkg::GLYPH_W-1:0]     glyph_r;
  logic [tgr_pkg::GLYPH_COLS-1:0]  colen_r;
  logic [tgr_pkg::COLOR_W-1:0]     ink_r;
  logic                            out_valid_r;
  tgr_pkg::tgr_out_t               out_r;

  logic out_free;
  logic emit;
  logic last_row;
  logic load;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = active_r && out_free;

  // Visible rows form a prefix, so the last one is the seventh or the one at the bottom edge
  assign last_row = (row_r == tgr_pkg::ROW_W'(tgr_pkg::GLYPH_ROWS - 1)) ||
                    (({1'b0, y_r} + 1'b1) >= cfg.hlim);

  // Next job enters in the same cycle the current one finishes
  assign load  = q_valid && (!active_r || (emit && last_row));
  assign q_pop = load;

  always_comb begin
    active_nxt = active_r;
    if (load) active_nxt = 1'b1;
    else if (emit && last_row) active_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (out_free) out_valid_r <= emit;
    end
  end

  // Row walk: offset grows by one pitch per row
  always_ff @(posedge clk) begin
    if (load) begin
      off_r   <= tgr_pkg::OFF_W'(q_head.prod) + tgr_pkg::OFF_W'(q_head.cx);
      y_r     <= q_head.cy;
      row_r   <= '0;
      glyph_r <= q_head.glyph;
      colen_r <= q_head.colen;
      ink_r   <= q_head.ink;
    end else if (emit) begin
      off_r   <= off_r + tgr_pkg::OFF_W'(cfg.pitch);
      y_r     <= y_r + 1'b1;
      row_r   <= row_r + 1'b1;
      glyph_r <= glyph_r << tgr_pkg::GLYPH_COLS;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.row_address <= cfg.base + tgr_pkg::ADDR_W'({off_r, 2'b00});
      out_r.pixel_mask  <= glyph_r[tgr_pkg::GLYPH_W-1 -: tgr_pkg::GLYPH_COLS] & colen_r;
      out_r.pixel_color <= ink_r;
      out_r.last        <= last_row;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### design/text_glyph_renderer_5x7_top.sv
// text_glyph_renderer_5x7_top: 5x7 text renderer top level with frame settings.
// Instantiates tgr_front, tgr_queue and tgr_back; depends on tgr_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one character request each,
//   with a first-of-string flag, the string origin and the ink color.
//   Output channel (out_valid / out_stall / out_data): one row write request per
//   visible glyph row, top row first; last marks the final row of a character.
//   cfg_we / cfg_index / cfg_data write the frame settings while idle.
//   A drawn character passes through the job queue and the row walker to the
//   registered output. Throughput is set by the row walker in the back end: one
//   row write per cycle while out_stall is low, one per visible row (up to 7)
//   of a character; newlines and undrawn characters queue no job.
//   A two-entry queue lets the input keep flowing while rows are written.
//   Reset clears the cursor, the frame settings (frame not ready) and the queue.
//   When out_stall is high the current row write holds and the row walker waits;
//   once the queue fills, in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module text_glyph_renderer_5x7_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire tgr_pkg::tgr_in_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output tgr_pkg::tgr_out_t                     out_data,
  input  wire logic                             cfg_we,
  input  wire logic [tgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tgr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tgr_pkg::tgr_cfg_t cfg_r;
  tgr_pkg::tgr_job_t push_data;
  tgr_pkg::tgr_job_t q_head;
  logic              q_push, q_ready, q_pop, q_valid;

  // Frame settings; limits are stored already capped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tgr_pkg::CFG_FRAME_READY:  cfg_r.ready <= cfg_data[0];
        tgr_pkg::CFG_FRAME_WIDTH:
          cfg_r.wlim  <= tgr_pkg::cap_dim(cfg_data[tgr_pkg::DIM_REG_W-1:0]);
        tgr_pkg::CFG_FRAME_HEIGHT:
          cfg_r.hlim  <= tgr_pkg::cap_dim(cfg_data[tgr_pkg::DIM_REG_W-1:0]);
        tgr_pkg::CFG_ROW_PITCH:    cfg_r.pitch <= cfg_data[tgr_pkg::PITCH_W-1:0];
        tgr_pkg::CFG_FRAME_BASE:   cfg_r.base  <= cfg_data[tgr_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  tgr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  tgr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  tgr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Queue is never popped empty or pushed full
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("job popped from empty queue");

  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready) else $error("job pushed into full queue");

  // A newline only moves the cursor, it never queues a job
  a_newline_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.character == tgr_pkg::NEWLINE_CODE) |-> !q_push)
    else $error("newline queued a job");

  // With the frame not ready nothing enters the back end
  a_not_ready_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_r.ready |-> !q_push) else $error("job queued while frame not ready");

endmodule

`default_nettype wire
